### sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Status codes, request modes, parameter defaults and the cell control group.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY_DEF       = 16;
  localparam int DATA_WIDTH_DEF     = 32;
  localparam int PRIORITY_WIDTH_DEF = 16;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // broadcast to every cell of the chain for one transfer
  typedef struct packed {
    logic enq;   // insert the new entry
    logic deq;   // pop the head, shift the rest up
  } cell_ctrl_t;

endpackage

### sv/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue in a chain of sorted cells
// Enqueue inserts behind entries of equal or higher priority; dequeue pops
// the head. Each request gives one result with status and occupancy.
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  request   in_mode, in_item_data, in_item_priority      start && !busy
//  result    out_status, out_data, out_occupancy,          out_valid, 1 cycle
//            out_is_empty, out_is_full
//
//  One request per cycle: every cell compares against the new priority and
//  loads itself in the same cycle the request is taken, so busy stays low.
//  The result appears on the cycle after the transfer, for one cycle only.
//  Synchronous reset empties the queue; cell contents are not cleared.
//  The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY       = spq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH     = spq_pkg::DATA_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic [DATA_WIDTH-1:0]             in_item_data,
  input  logic signed [PRIORITY_WIDTH-1:0]  in_item_priority,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [DATA_WIDTH-1:0]             out_data,
  output logic [$clog2(CAPACITY+1)-1:0]     out_occupancy,
  output logic                              out_is_empty,
  output logic                              out_is_full
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic                             accept;
  logic                             is_full_now, is_empty_now;
  cell_ctrl_t                       ctrl;
  logic [CW-1:0]                    count_r, count_nxt;
  status_t                          status_nxt;
  logic [DATA_WIDTH-1:0]            data_nxt;

  logic                             valid_r;
  logic [1:0]                       status_r;
  logic [DATA_WIDTH-1:0]            data_r;
  logic [CW-1:0]                    occ_r;
  logic                             empty_r, full_r;

  logic [DATA_WIDTH-1:0]            cell_data [CAPACITY];
  logic signed [PRIORITY_WIDTH-1:0] cell_prio [CAPACITY];
  logic                             cell_disp [CAPACITY];

  assign busy         = 1'b0;
  assign accept       = start && !busy;
  assign is_full_now  = (count_r == CAP);
  assign is_empty_now = (count_r == '0);

  always_comb begin
    ctrl       = '0;
    count_nxt  = count_r;
    status_nxt = STATUS_OK;
    data_nxt   = '0;
    if (accept) begin
      if (in_mode == MODE_ENQ) begin
        if (is_full_now) begin
          status_nxt = STATUS_FULL;
        end else begin
          ctrl.enq  = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (is_empty_now) begin
          status_nxt = STATUS_EMPTY;
        end else begin
          ctrl.deq  = 1'b1;
          data_nxt  = cell_data[0];
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0]            l_data, r_data;
      logic signed [PRIORITY_WIDTH-1:0] l_prio, r_prio;
      logic                             l_disp;

      if (i == 0) begin : g_head
        assign l_data = cell_data[i];
        assign l_prio = cell_prio[i];
        assign l_disp = 1'b0;
      end else begin : g_body
        assign l_data = cell_data[i-1];
        assign l_prio = cell_prio[i-1];
        assign l_disp = cell_disp[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        // last slot holds on pop: it falls out of the occupied range
        assign r_data = cell_data[i];
        assign r_prio = cell_prio[i];
      end else begin : g_inner
        assign r_data = cell_data[i+1];
        assign r_prio = cell_prio[i+1];
      end

      spq_cell #(
        .INDEX          (i),
        .CNT_WIDTH      (CW),
        .DATA_WIDTH     (DATA_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_r),
        .new_data   (in_item_data),
        .new_prio   (in_item_priority),
        .left_data  (l_data),
        .left_prio  (l_prio),
        .left_disp  (l_disp),
        .right_data (r_data),
        .right_prio (r_prio),
        .data       (cell_data[i]),
        .prio       (cell_prio[i]),
        .disp       (cell_disp[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    data_r   <= data_nxt;
    occ_r    <= count_nxt;
    empty_r  <= (count_nxt == '0);
    full_r   <= (count_nxt == CAP);
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_data      = data_r;
  assign out_occupancy = occ_r;
  assign out_is_empty  = empty_r;
  assign out_is_full   = full_r;

  // a result follows every transfer, in the next cycle
  a_result_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("result strobe missing after transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("entry count beyond capacity");

  a_occ_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy == count_r))
    else $error("reported occupancy differs from held count");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_ENQ && count_r == CAP) |=> $stable(count_r))
    else $error("rejected enqueue changed the queue");

endmodule

### sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbour's entry; on pop it takes its right neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int INDEX          = 0,
  parameter int CNT_WIDTH      = 5,
  parameter int DATA_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                             clk,
  input  spq_pkg::cell_ctrl_t              ctrl,
  input  logic [CNT_WIDTH-1:0]             count,
  input  logic [DATA_WIDTH-1:0]            new_data,
  input  logic signed [PRIORITY_WIDTH-1:0] new_prio,
  input  logic [DATA_WIDTH-1:0]            left_data,
  input  logic signed [PRIORITY_WIDTH-1:0] left_prio,
  input  logic                             left_disp,
  input  logic [DATA_WIDTH-1:0]            right_data,
  input  logic signed [PRIORITY_WIDTH-1:0] right_prio,
  output logic [DATA_WIDTH-1:0]            data,
  output logic signed [PRIORITY_WIDTH-1:0] prio,
  output logic                             disp
);
  import spq_pkg::*;

  localparam logic [CNT_WIDTH-1:0] IDX = CNT_WIDTH'(INDEX);

  logic [DATA_WIDTH-1:0]            data_r, data_nxt;
  logic signed [PRIORITY_WIDTH-1:0] prio_r, prio_nxt;
  logic                             occ;

  assign occ  = count > IDX;
  // held entry moves down when the new one outranks it
  assign disp = occ && (new_prio > prio_r);

  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (ctrl.enq) begin
      if (left_disp) begin
        data_nxt = left_data;
        prio_nxt = left_prio;
      end else if (!occ || disp) begin
        data_nxt = new_data;
        prio_nxt = new_prio;
      end
    end else if (ctrl.deq) begin
      data_nxt = right_data;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign data = data_r;
  assign prio = prio_r;

endmodule
